// ===== rtl/bsoc_pkg.sv =====
// Shared types and constants of the battery test cycle sequencer.
package bsoc_pkg;

	localparam int PCT_W   = 7;
	localparam int PHASE_W = 4;
	localparam int CAP_W   = 2;
	localparam int GUARD_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL  = 1'd1;

	localparam logic [PCT_W-1:0] HIGH_LEVEL_RESET = 7'd80;
	localparam logic [PCT_W-1:0] LOW_LEVEL_RESET  = 7'd10;

	localparam logic [PHASE_W-1:0] PH_IDLE           = 4'd0;
	localparam logic [PHASE_W-1:0] PH_START          = 4'd1;
	localparam logic [PHASE_W-1:0] PH_REST_HIGH      = 4'd2;
	localparam logic [PHASE_W-1:0] PH_CHARGE_UP      = 4'd3;
	localparam logic [PHASE_W-1:0] PH_DISCHARGE_DOWN = 4'd4;
	localparam logic [PHASE_W-1:0] PH_DISCHARGE_LOW  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_REST_LOW       = 4'd6;
	localparam logic [PHASE_W-1:0] PH_CHARGE_HIGH    = 4'd7;
	localparam logic [PHASE_W-1:0] PH_REST_END       = 4'd8;

	localparam logic [CAP_W-1:0] CAP_NONE  = 2'd0;
	localparam logic [CAP_W-1:0] CAP_FIRST = 2'd1;
	localparam logic [CAP_W-1:0] CAP_MID   = 2'd2;
	localparam logic [CAP_W-1:0] CAP_LAST  = 2'd3;

	typedef struct packed {
		logic [PCT_W-1:0] charge_pct;
		logic             wait_over;
		logic             keep_alive_active;
		logic             partial_cycle_active;
		logic             set_cycle_enable;
		logic             set_autotest;
	} tick_t;

	typedef struct packed {
		logic               charge_on;
		logic               discharge_on;
		logic               timer_run;
		logic               timer_clear;
		logic [CAP_W-1:0]   capture_point;
		logic               params_read;
		logic               finished;
		logic [PHASE_W-1:0] phase_now;
	} result_t;

	typedef struct packed {
		logic [PCT_W-1:0] high_level_pct;
		logic [PCT_W-1:0] low_level_pct;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [GUARD_W-1:0] guards;
		logic               charge;
		logic               discharge;
		logic               timer_en;
		logic               params_done;
		logic               cycle_en;
		logic               autotest_req;
	} seq_state_t;

endpackage

// ===== rtl/bsoc_tick_if.sv =====
// Valid/ready channel that carries one poll tick item.
interface bsoc_tick_if import bsoc_pkg::*;;
	logic  valid;
	logic  ready;
	tick_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/bsoc_result_if.sv =====
// Valid/ready channel that carries one sequencer result item.
interface bsoc_result_if import bsoc_pkg::*;;
	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/bsoc_cfg.sv =====
// Level registers written through the configuration port.
module bsoc_cfg import bsoc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_level_pct <= HIGH_LEVEL_RESET;
			cfg_q.low_level_pct  <= LOW_LEVEL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_HIGH_LEVEL: cfg_q.high_level_pct <= cfg_wdata[PCT_W-1:0];
				REG_LOW_LEVEL:  cfg_q.low_level_pct  <= cfg_wdata[PCT_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/bsoc_step.sv =====
// Next-state and result logic for one poll tick of the test sequence.
module bsoc_step import bsoc_pkg::*; (
	input  seq_state_t st,
	input  cfg_t       cfg,
	input  tick_t      tick,
	output seq_state_t st_next,
	output result_t    res
);

	logic [PHASE_W-1:0] ph;
	logic [PHASE_W-1:0] ph_m1;
	logic [2:0]         gidx;
	logic               guard;
	logic               clr;
	logic [CAP_W-1:0]   cap;
	logic               prd;
	logic               fin;
	logic [PCT_W-1:0]   target;

	always_comb begin
		st_next = st;
		clr     = 1'b0;
		cap     = CAP_NONE;
		prd     = 1'b0;
		fin     = 1'b0;
		ph      = (st.phase == PH_IDLE) ? PH_START : st.phase;
		ph_m1   = ph - PHASE_W'(1);
		gidx    = ph_m1[2:0];
		guard   = st.guards[gidx];
		target  = (ph == PH_DISCHARGE_LOW) ? cfg.low_level_pct : cfg.high_level_pct;

		if (tick.set_cycle_enable) st_next.cycle_en = 1'b1;
		if (tick.set_autotest)     st_next.autotest_req = 1'b1;

		if (!tick.keep_alive_active && st_next.cycle_en && !tick.partial_cycle_active) begin
			if (st.phase == PH_IDLE) begin
				st_next.charge    = 1'b0;
				st_next.discharge = 1'b0;
			end
			if (st_next.autotest_req) begin
				if (!st.params_done) begin
					st_next.params_done = 1'b1;
					prd = 1'b1;
				end
				st_next.phase = ph;
				case (ph) inside
					PH_START: begin
						if (tick.charge_pct == cfg.high_level_pct)
							st_next.phase = PH_REST_HIGH;
						else if (tick.charge_pct < cfg.high_level_pct)
							st_next.phase = PH_CHARGE_UP;
						else
							st_next.phase = PH_DISCHARGE_DOWN;
					end
					PH_REST_HIGH, PH_REST_LOW, PH_REST_END: begin
						if (!guard) begin
							// First tick of a rest: drives off, rest timer running.
							st_next.charge       = 1'b0;
							st_next.discharge    = 1'b0;
							st_next.timer_en     = 1'b1;
							st_next.guards[gidx] = 1'b1;
						end else if (tick.wait_over) begin
							st_next.guards[gidx] = 1'b0;
							if (ph == PH_REST_HIGH) begin
								cap = CAP_FIRST;
								st_next.phase = PH_DISCHARGE_LOW;
							end else if (ph == PH_REST_LOW) begin
								cap = CAP_MID;
								st_next.phase = PH_CHARGE_HIGH;
							end else begin
								cap = CAP_LAST;
								clr = 1'b1;
								fin = 1'b1;
								st_next.timer_en     = 1'b0;
								st_next.autotest_req = 1'b0;
								st_next.cycle_en     = 1'b0;
								st_next.params_done  = 1'b0;
								st_next.phase        = PH_IDLE;
							end
						end
					end
					PH_CHARGE_UP, PH_DISCHARGE_DOWN, PH_DISCHARGE_LOW, PH_CHARGE_HIGH: begin
						if (!guard) begin
							st_next.charge    = (ph == PH_CHARGE_UP) || (ph == PH_CHARGE_HIGH);
							st_next.discharge = !((ph == PH_CHARGE_UP) || (ph == PH_CHARGE_HIGH));
							st_next.guards[gidx] = 1'b1;
							if ((ph == PH_DISCHARGE_LOW) || (ph == PH_CHARGE_HIGH)) begin
								st_next.timer_en = 1'b0;
								clr = 1'b1;
							end
						end else if (tick.charge_pct == target) begin
							st_next.guards[gidx] = 1'b0;
							if (ph == PH_DISCHARGE_LOW)
								st_next.phase = PH_REST_LOW;
							else if (ph == PH_CHARGE_HIGH)
								st_next.phase = PH_REST_END;
							else
								st_next.phase = PH_REST_HIGH;
						end
					end
					default: st_next.phase = PH_IDLE;
				endcase
			end
		end

		res.charge_on     = st_next.charge;
		res.discharge_on  = st_next.discharge;
		res.timer_run     = st_next.timer_en;
		res.timer_clear   = clr;
		res.capture_point = cap;
		res.params_read   = prd;
		res.finished      = fin;
		res.phase_now     = st_next.phase;
	end

endmodule

// ===== rtl/battery_soc_test_cycle_sequencer_core.sv =====
// Top level of the battery state-of-charge test cycle sequencer.
//
// Each item on the tick channel is one poll of the battery: measured charge,
// rest timer expired flag, inhibit flags and start requests. For every tick
// the block returns exactly one item on the result channel with the drive
// commands, timer commands, capture and parameter pulses, the finished pulse
// and the phase after the tick.
// The two level registers are written through cfg_we / cfg_idx / cfg_wdata;
// the user must write them only while no tick is in flight, as the block leaves this unchecked.
// The result is registered: a tick accepted at one edge has its result
// valid after that edge. Throughput is one tick per cycle while the
// receiver takes each result; the sequencer state is updated in the cycle
// the tick is accepted, so the single result register is the only stage.
// When the receiver stalls, the result register holds its item and a new
// tick is taken only in a cycle where that item leaves.
// Reset clears the phase, guards, drives and flags, empties the result
// register and loads the levels with 80 and 10 percent.
module battery_soc_test_cycle_sequencer_core import bsoc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	bsoc_tick_if.sink             tick,
	bsoc_result_if.source         result
);

	cfg_t       cfg;
	seq_state_t state_q;
	seq_state_t state_next;
	result_t    res_next;
	result_t    res_q;
	logic       res_valid_q;
	logic       take;

	bsoc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	bsoc_step u_step (
		.st     (state_q),
		.cfg    (cfg),
		.tick   (tick.data),
		.st_next(state_next),
		.res    (res_next)
	);

	assign tick.ready = !res_valid_q || result.ready;
	assign take       = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q     <= state_next;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= res_next;
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

// ===== rtl/bsoc_checker.sv =====
// Port-level checks on the sequencer result channel, bound to the top level.
module bsoc_checker import bsoc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result item changed while stalled");

	a_one_drive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.charge_on && res.discharge_on))
		else $error("charge and discharge driven together");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.finished |-> res.phase_now == PH_IDLE &&
			res.capture_point == CAP_LAST && res.timer_clear && !res.timer_run)
		else $error("finished item without final capture and idle phase");

	a_first_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.capture_point == CAP_FIRST |->
			res.phase_now == PH_DISCHARGE_LOW && res.timer_run)
		else $error("first capture outside the rest to discharge step");

endmodule

bind battery_soc_test_cycle_sequencer_core bsoc_checker u_bsoc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res      (result.data)
);
